>>> rtl/core/msp_pkg.sv
// Shared constants for the multi-stack shared-pool block.
package msp_pkg;

  // Default sizes of the block.
  localparam int DEF_NUM_STACKS = 4;
  localparam int DEF_CAPACITY   = 16;

  // Fixed field widths of a request and a response.
  localparam int VALUE_W  = 32;
  localparam int ID_W     = 2;
  localparam int STATUS_W = 2;

  // Request operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

endpackage

>>> rtl/core/multi_stack_shared_pool.sv
// Top level of the multi-stack shared-pool block: several LIFO stacks in one entry pool.
// Sequence: a push or a failed request passes S_TOP and then S_OUT; a pop passes S_TOP, S_POP and S_OUT.
// Requests: one at a time; a new request is taken only once the current one has left S_OUT,
// set by the read-modify-write sequence through the registered-read entry RAM and stack-top RAM.
// A finished response waits in the output register while the next request is taken.
// Reset: synchronous; stack-top valid bits clear at once, the free list restarts through a
// fill count (no clearing pass), and value entries are undefined until pushed.
module multi_stack_shared_pool #(
  parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
  parameter int CAPACITY   = msp_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                req_type,
  input  logic [msp_pkg::ID_W-1:0]            stack_id,
  input  logic signed [msp_pkg::VALUE_W-1:0]  push_value,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic signed [msp_pkg::VALUE_W-1:0]  pop_value,
  output logic [msp_pkg::STATUS_W-1:0]        status
);

  import msp_pkg::*;

  // Entry addresses, links (with null coded as CAPACITY) and stack-top addresses.
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int EW = VALUE_W + LW;
  localparam int TW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SW = (TW > ID_W) ? TW : ID_W;
  localparam logic [LW-1:0] LINK_NULL = LW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,
    S_POP,
    S_OUT
  } state_t;

  state_t state;

  // Request held while it is worked on.
  logic                      op_type;
  logic [ID_W-1:0]           op_sid;
  logic [TW-1:0]             op_tsel;
  logic signed [VALUE_W-1:0] op_value;

  // Pool bookkeeping.
  logic [LW-1:0]          free_head;
  logic [LW-1:0]          fill;
  logic [(1 << TW)-1:0]   tops_vld;
  logic [LW-1:0]          pop_slot;

  // Pending response.
  logic signed [VALUE_W-1:0] res_value;
  logic [STATUS_W-1:0]       res_status;

  // RAM ports.
  logic          ent_we;
  logic [AW-1:0] ent_waddr;
  logic [EW-1:0] ent_wdata;
  logic [AW-1:0] ent_raddr;
  logic [EW-1:0] ent_rdata;
  logic          tops_we;
  logic [LW-1:0] tops_wdata;
  logic [TW-1:0] tops_raddr;
  logic [LW-1:0] tops_rdata;

  // Decoded values.
  logic [SW-1:0]             sid_ext;
  logic                      sid_ok;
  logic [LW-1:0]             top_cur;
  logic                      fh_ok;
  logic                      fresh;
  logic [LW-1:0]             ent_link;
  logic [LW-1:0]             ent_link_clean;
  logic signed [VALUE_W-1:0] ent_rvalue;
  logic [LW-1:0]             free_next_push;
  logic                      push_go;
  logic                      pop_go;

  assign req_ready = (state == S_IDLE);

  // Stack number translated to a stack-top RAM address.
  assign sid_ext    = SW'(stack_id);
  assign tops_raddr = sid_ext[TW-1:0];

  // Current request decode against the RAM read data.
  always_comb begin
    sid_ok         = (32'(op_sid) < 32'(NUM_STACKS));
    top_cur        = (sid_ok && tops_vld[op_tsel] && (tops_rdata < LINK_NULL)) ?
                     tops_rdata : LINK_NULL;
    fh_ok          = (free_head < LINK_NULL);
    fresh          = (free_head >= fill);
    ent_link       = ent_rdata[LW-1:0];
    ent_rvalue     = ent_rdata[EW-1:LW];
    ent_link_clean = (ent_link < LINK_NULL) ? ent_link : LINK_NULL;
    free_next_push = fresh ? (free_head + LW'(1)) : ent_link_clean;
    push_go        = (state == S_TOP) && (op_type == OP_PUSH) && sid_ok && fh_ok;
    pop_go         = (state == S_TOP) && (op_type == OP_POP) && (top_cur != LINK_NULL);
  end

  // Entry RAM and stack-top RAM access steering.
  always_comb begin
    ent_raddr  = (state == S_TOP) ? top_cur[AW-1:0] : free_head[AW-1:0];
    ent_we     = push_go || (state == S_POP);
    ent_waddr  = push_go ? free_head[AW-1:0] : pop_slot[AW-1:0];
    ent_wdata  = push_go ? {op_value, top_cur} : {ent_rvalue, free_head};
    tops_we    = push_go || (state == S_POP);
    tops_wdata = push_go ? free_head : ent_link_clean;
  end

  msp_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  msp_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_STACKS)
  ) u_tops_ram (
    .clk   (clk),
    .we    (tops_we),
    .waddr (op_tsel),
    .wdata (tops_wdata),
    .raddr (tops_raddr),
    .rdata (tops_rdata)
  );

  // Sequencer, pool registers and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      fill      <= '0;
      tops_vld  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A taken response clears here unless a new one is loaded below.
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_type  <= req_type;
            op_sid   <= stack_id;
            op_tsel  <= tops_raddr;
            op_value <= push_value;
            state    <= S_TOP;
          end
        end
        S_TOP: begin
          res_value <= '0;
          state     <= S_OUT;
          if (push_go) begin
            free_head         <= free_next_push;
            tops_vld[op_tsel] <= 1'b1;
            res_status        <= ST_OK;
            if (fresh) begin
              fill <= free_head + LW'(1);
            end
          end else if (op_type == OP_PUSH) begin
            res_status <= ST_OVERFLOW;
          end else if (pop_go) begin
            pop_slot <= top_cur;
            state    <= S_POP;
          end else begin
            res_status <= ST_EMPTY;
          end
        end
        S_POP: begin
          free_head  <= pop_slot;
          res_value  <= ent_rvalue;
          res_status <= ST_OK;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            pop_value <= res_value;
            status    <= res_status;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the pool size.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= LINK_NULL)
    else $error("fill count beyond pool size");

  // The free head is an entry or null, never beyond.
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= LINK_NULL)
    else $error("free head out of range");

  // A push from the untouched region takes exactly the next fresh entry.
  a_fresh_contig: assert property (@(posedge clk) disable iff (rst)
    (push_go && fresh) |-> (free_head == fill))
    else $error("fresh allocation not contiguous");

  // Entry RAM is written only while a request is being worked on.
  a_ent_we_state: assert property (@(posedge clk) disable iff (rst)
    ent_we |-> ((state == S_TOP) || (state == S_POP)))
    else $error("entry write outside the request sequence");

  // An accepted request moves straight to the stack-top lookup.
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_TOP))
    else $error("accepted request did not start lookup");

endmodule

>>> rtl/core/msp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the address being written sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sim/multi_stack_shared_pool_tb.sv
// Self-checking testbench for the multi-stack shared-pool block.
`timescale 1ns / 100ps

module multi_stack_shared_pool_tb;
  import msp_pkg::*;

  localparam int NS = DEF_NUM_STACKS;
  localparam int CAP = DEF_CAPACITY;
  localparam int LINK_W = $clog2(CAP + 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(CAP);
  localparam int RANDOM_REQS = 1550;
  localparam int IDLE_LIMIT = 1000;

  typedef struct {
    logic op;
    logic [ID_W-1:0] sid;
    logic signed [VALUE_W-1:0] val;
    bit drain;
  } pool_req_t;

  typedef struct {
    logic signed [VALUE_W-1:0] val;
    logic [STATUS_W-1:0] st;
  } pool_rsp_t;

  typedef enum {PLAN_FILL, PLAN_DRAIN, PLAN_MIXED} plan_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic req_type = OP_PUSH;
  logic [ID_W-1:0] stack_id = '0;
  logic signed [VALUE_W-1:0] push_value = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic signed [VALUE_W-1:0] pop_value;
  logic [STATUS_W-1:0] status;

  // Pending requests in issue order and responses still owed by the block.
  pool_req_t req_backlog[$];
  pool_rsp_t rsp_expected[$];

  // Shadow copy of the pool, updated as each request is accepted.
  logic signed [VALUE_W-1:0] shadow_val[CAP];
  logic [LINK_W-1:0] shadow_link[CAP];
  logic [LINK_W-1:0] shadow_top[NS];
  logic [LINK_W-1:0] shadow_free;

  // Occupancy seen while planning, used to steer the random requests.
  int plan_depth[NS];
  int plan_used;

  int err_count = 0;
  int idle_cycles = 0;
  int req_gap = 0;
  int rsp_stall = 0;
  bit req_fire = 1'b0;
  bit feed_done = 1'b0;
  bit quiet_req = 1'b0;
  bit quiet_rsp = 1'b0;

  multi_stack_shared_pool #(
    .NUM_STACKS(NS),
    .CAPACITY(CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_type(req_type),
    .stack_id(stack_id),
    .push_value(push_value),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .pop_value(pop_value),
    .status(status)
  );

  always #5 clk = ~clk;

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic pool_clear();
    for (int i = 0; i < CAP; i++) begin
      shadow_val[i] = '0;
      shadow_link[i] = (i == CAP - 1) ? LINK_NULL : LINK_W'(i + 1);
    end
    for (int s = 0; s < NS; s++) shadow_top[s] = LINK_NULL;
    shadow_free = '0;
  endtask

  // Applies one request to the shadow pool and returns the response it owes.
  task automatic pool_apply(input pool_req_t r, output pool_rsp_t y);
    logic [LINK_W-1:0] slot;
    y.val = '0;
    y.st = ST_OK;
    if (r.op == OP_PUSH) begin
      if (int'(r.sid) >= NS || shadow_free >= LINK_NULL) begin
        y.st = ST_OVERFLOW;
      end else begin
        slot = shadow_free;
        shadow_free = (shadow_link[slot] < LINK_NULL) ? shadow_link[slot] : LINK_NULL;
        shadow_val[slot] = r.val;
        shadow_link[slot] = shadow_top[r.sid];
        shadow_top[r.sid] = slot;
      end
    end else begin
      if (int'(r.sid) >= NS || shadow_top[r.sid] >= LINK_NULL) begin
        y.st = ST_EMPTY;
      end else begin
        slot = shadow_top[r.sid];
        shadow_top[r.sid] = (shadow_link[slot] < LINK_NULL) ? shadow_link[slot] : LINK_NULL;
        shadow_link[slot] = shadow_free;
        shadow_free = slot;
        y.val = shadow_val[slot];
      end
    end
  endtask

  // Queues one request and tracks how full the pool will be after it.
  task automatic plan_request(input logic op, input int sid, input logic [31:0] val,
                              input bit drain);
    pool_req_t r;
    r.op = op;
    r.sid = ID_W'(sid);
    r.val = val;
    r.drain = drain;
    req_backlog.push_back(r);
    if (op == OP_PUSH && plan_used < CAP) begin
      plan_depth[sid]++;
      plan_used++;
    end else if (op == OP_POP && plan_depth[sid] > 0) begin
      plan_depth[sid]--;
      plan_used--;
    end
  endtask

  // Request driver: holds each request until taken, then pauses or moves on.
  always @(negedge clk) begin : req_driver
    pool_req_t nxt;
    if ($urandom_range(0, 199) == 0) quiet_req <= !quiet_req;
    if (rst) begin
      req_valid <= 1'b0;
      req_gap <= 0;
    end else if (req_valid && !req_fire) begin
      // The current request is still waiting for the block.
    end else if (req_gap != 0) begin
      req_valid <= 1'b0;
      req_gap <= req_gap - 1;
    end else if (req_backlog.size() != 0 && req_backlog[0].drain &&
                 rsp_expected.size() != 0) begin
      // Let every owed response come back before this request goes out.
      req_valid <= 1'b0;
    end else if (req_backlog.size() != 0) begin
      nxt = req_backlog.pop_front();
      req_type <= nxt.op;
      stack_id <= nxt.sid;
      push_value <= nxt.val;
      req_valid <= 1'b1;
      req_gap <= quiet_req ? 0 : pick_pause();
    end else begin
      req_valid <= 1'b0;
      feed_done <= 1'b1;
    end
  end

  // Response sink with random back-pressure.
  always @(negedge clk) begin : rsp_sink
    if ($urandom_range(0, 199) == 0) quiet_rsp <= !quiet_rsp;
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_stall <= 0;
    end else if (rsp_stall != 0) begin
      rsp_ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else if (quiet_rsp || $urandom_range(0, 3) != 0) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= 1'b0;
      rsp_stall <= pick_pause();
    end
  end

  // Monitor: checks each response, then predicts the request taken this edge.
  always @(posedge clk) begin : pool_monitor
    pool_req_t taken;
    pool_rsp_t want;
    if (rst) begin
      pool_clear();
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        if (rsp_expected.size() == 0) begin
          report_mismatch($sformatf("response with none owed: pop_value %0d status %0d",
                                    pop_value, status));
        end else begin
          want = rsp_expected.pop_front();
          if (pop_value !== want.val)
            report_mismatch($sformatf("pop_value %0d, expected %0d", pop_value, want.val));
          if (status !== want.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
        end
      end
      if (req_valid && req_ready) begin
        taken.op = req_type;
        taken.sid = stack_id;
        taken.val = push_value;
        taken.drain = 1'b0;
        pool_apply(taken, want);
        rsp_expected.push_back(want);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin : stimulus
    logic [31:0] corner[4];
    plan_mode_t mode;
    int favored;
    int sid;
    logic op;
    logic [31:0] val;
    corner[0] = 32'h8000_0000;
    corner[1] = 32'h7FFF_FFFF;
    corner[2] = 32'h0000_0000;
    corner[3] = 32'hFFFF_FFFF;
    for (int s = 0; s < NS; s++) plan_depth[s] = 0;
    plan_used = 0;

    // Pops from every empty stack.
    for (int s = 0; s < NS; s++) plan_request(OP_POP, s, $urandom(), 1'b0);
    // Fill the whole pool with extreme and random values spread over the stacks.
    for (int i = 0; i < CAP; i++) begin
      if (i < 4) val = corner[i];
      else if (i == 4) val = 32'h5555_5555;
      else if (i == 5) val = 32'hAAAA_AAAA;
      else val = $urandom();
      plan_request(OP_PUSH, i % NS, val, 1'b0);
    end
    // Push into a full pool, then pop once from each stack.
    plan_request(OP_PUSH, 2, 32'h1234_5678, 1'b0);
    for (int s = NS - 1; s >= 0; s--) plan_request(OP_POP, s, $urandom(), 1'b0);

    // Random part: swings between filling and draining the pool.
    mode = PLAN_MIXED;
    favored = 0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (plan_used == CAP && $urandom_range(0, 2) == 0) mode = PLAN_DRAIN;
      else if (plan_used == 0 && $urandom_range(0, 2) == 0)
        mode = $urandom_range(0, 1) ? PLAN_FILL : PLAN_MIXED;
      else if ($urandom_range(0, 49) == 0) mode = plan_mode_t'($urandom_range(0, 2));
      if ($urandom_range(0, 31) == 0) favored = $urandom_range(0, NS - 1);
      sid = $urandom_range(0, 1) ? favored : $urandom_range(0, NS - 1);
      case (mode)
        PLAN_FILL: op = ($urandom_range(0, 99) < 85) ? OP_PUSH : OP_POP;
        PLAN_DRAIN: op = ($urandom_range(0, 99) < 85) ? OP_POP : OP_PUSH;
        default: op = $urandom_range(0, 1) ? OP_POP : OP_PUSH;
      endcase
      val = ($urandom_range(0, 15) == 0) ? corner[$urandom_range(0, 3)] : $urandom();
      plan_request(op, sid, val, n == 0 || $urandom_range(0, 199) == 0);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!feed_done || rsp_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> multi_stack_shared_pool.f
rtl/core/msp_pkg.sv
rtl/core/msp_ram.sv
rtl/core/multi_stack_shared_pool.sv
sim/multi_stack_shared_pool_tb.sv
